@@ src/csc_pkg.sv @@
// Shared types and constants for the clipped stamp compositor.
// No dependencies; every file but the two channel interfaces imports this package.
package csc_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_BLANK = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [7:0] IMAGE_SIZE_RESET = 8'd128;

  localparam logic signed [31:0] PIX_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PIX_MIN = 32'sh8000_0000;

  // Controller to datapath
  typedef struct packed {
    logic ld_in;     // capture the input beat
    logic ld_addr;   // register target address, hit flag and product
    logic ld_rd;     // read the frame store, register rounded term
    logic ld_out;    // update pixel, load the output register
    logic clr_step;  // write zero at the clear counter and advance
  } csc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;  // clear counter at the last entry
    logic out_busy;  // output register holds a beat not taken this cycle
  } csc_sts_t;

endpackage

@@ src/csc_in_if.sv @@
// Input channel of the clipped stamp compositor: one stamp pixel per beat.
// Depends on nothing but the payload field widths.
interface csc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [7:0]         stamp_width;
  logic [7:0]         stamp_height;
  logic signed [8:0]  anchor_x;
  logic signed [8:0]  anchor_y;
  logic [6:0]         local_x;
  logic [6:0]         local_y;
  logic signed [31:0] sample;
  logic signed [31:0] factor;
  logic               mask_keep;

  modport source (output valid, operation, stamp_width, stamp_height, anchor_x, anchor_y,
                  local_x, local_y, sample, factor, mask_keep, input ready);
  modport sink   (input valid, operation, stamp_width, stamp_height, anchor_x, anchor_y,
                  local_x, local_y, sample, factor, mask_keep, output ready);
endinterface

@@ src/csc_out_if.sv @@
// Result channel of the clipped stamp compositor: one pixel result per beat.
// Depends on nothing but the payload field widths.
interface csc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_value;
  logic               inside_res;

  modport source (output valid, pixel_value, inside_res, input ready);
  modport sink   (input valid, pixel_value, inside_res, output ready);
endinterface

@@ src/csc_ctrl.sv @@
// Controller of the clipped stamp compositor: clearing pass, then a
// four-step sequence per item. Depends on csc_pkg.
module csc_ctrl
  import csc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  csc_sts_t sts,
  output csc_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_RD,
    S_MOD
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.ld_in  = in_valid;
        if (in_valid) state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.ld_addr = 1'b1;
        state_nxt   = S_RD;
      end
      S_RD: begin
        // re-read while the previous result still waits; reads are harmless
        cmd.ld_rd = 1'b1;
        if (!sts.out_busy) state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.ld_out = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  a_no_out_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ld_out && sts.out_busy))
    else $error("output register overwritten while a beat waits");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_in |=> !in_ready)
    else $error("second item accepted while one is in flight");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !in_ready && !cmd.ld_out)
    else $error("item activity during the clearing pass");

endmodule

@@ src/csc_dp.sv @@
// Datapath of the clipped stamp compositor: frame store, address and clip
// logic, multiply-round-saturate, output register. Depends on csc_pkg.
module csc_dp
  import csc_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  csc_cmd_t           cmd,
  output csc_sts_t           sts,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic [1:0]         operation,
  input  logic [7:0]         stamp_width,
  input  logic [7:0]         stamp_height,
  input  logic signed [8:0]  anchor_x,
  input  logic signed [8:0]  anchor_y,
  input  logic [6:0]         local_x,
  input  logic [6:0]         local_y,
  input  logic signed [31:0] sample,
  input  logic signed [31:0] factor,
  input  logic               mask_keep,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] pixel_value,
  output logic               inside_res
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  logic signed [31:0] mem [DEPTH];

  logic [7:0]         img_w_r, img_h_r;
  logic [1:0]         op_r;
  logic [7:0]         sw_r, sh_r;
  logic signed [8:0]  ax_r, ay_r;
  logic [6:0]         lx_r, ly_r;
  logic signed [31:0] sample_r, factor_r;
  logic               keep_r;

  logic [AW-1:0]      addr_r, addr_nxt;
  logic               hit_r, hit_nxt;
  logic signed [63:0] prod_r;
  logic signed [31:0] rd_r, term_r, term_nxt;
  logic signed [31:0] out_pix_r, pix_nxt;
  logic               out_inside_r;
  logic               out_valid_r;
  logic [AW-1:0]      clr_r;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMAGE_SIZE_RESET;
      img_h_r <= IMAGE_SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IMAGE_WIDTH) img_w_r <= cfg_wdata;
      if (cfg_index == CFG_IMAGE_HEIGHT) img_h_r <= cfg_wdata;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_r     <= operation;
      sw_r     <= stamp_width;
      sh_r     <= stamp_height;
      ax_r     <= anchor_x;
      ay_r     <= anchor_y;
      lx_r     <= local_x;
      ly_r     <= local_y;
      sample_r <= sample;
      factor_r <= factor;
      keep_r   <= mask_keep;
    end
  end

  // Target coordinates and clipping
  logic signed [10:0] tx, ty;
  logic [10:0]        w_eff, h_eff;
  logic               in_frame, in_stamp;

  always_comb begin
    w_eff = ({3'b000, img_w_r} > 11'(MAX_WIDTH))  ? 11'(MAX_WIDTH)  : {3'b000, img_w_r};
    h_eff = ({3'b000, img_h_r} > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : {3'b000, img_h_r};
    in_stamp = ({1'b0, lx_r} < sw_r) && ({1'b0, ly_r} < sh_r);
    case (op_r)
      OP_ADD: begin
        tx = 11'(ax_r) - $signed({4'b0000, sw_r[7:1]}) + $signed({4'b0000, lx_r});
        ty = 11'(ay_r) - $signed({4'b0000, sh_r[7:1]}) + $signed({4'b0000, ly_r});
      end
      OP_BLANK: begin
        tx = 11'(ax_r) + $signed({4'b0000, lx_r});
        ty = 11'(ay_r) + $signed({4'b0000, ly_r});
      end
      default: begin
        tx = 11'(ax_r);
        ty = 11'(ay_r);
      end
    endcase
    in_frame = !tx[10] && !ty[10] && ({1'b0, tx[9:0]} < w_eff) && ({1'b0, ty[9:0]} < h_eff);
    case (op_r)
      OP_ADD, OP_BLANK: hit_nxt = in_frame && in_stamp;
      OP_READ:          hit_nxt = in_frame;
      default:          hit_nxt = 1'b0;
    endcase
    addr_nxt = AW'(ty[9:0]) * AW'(MAX_WIDTH) + AW'(tx[9:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_addr) begin
      addr_r <= addr_nxt;
      hit_r  <= hit_nxt;
      prod_r <= 64'(sample_r) * 64'(factor_r);
    end
  end

  // Round the Q32.32 product to Q16.16 and saturate
  logic signed [63:0] rnd;
  always_comb begin
    rnd = prod_r + 64'sd32768;
    if ((&rnd[63:47]) || !(|rnd[63:47])) begin
      term_nxt = rnd[47:16];
    end else begin
      term_nxt = rnd[63] ? PIX_MIN : PIX_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_rd) begin
      rd_r   <= mem[addr_r];
      term_r <= term_nxt;
    end
  end

  // Pixel update
  logic signed [32:0] sum;
  logic signed [31:0] sum_sat;
  logic               upd_we;

  always_comb begin
    sum     = 33'(rd_r) + 33'(term_r);
    sum_sat = (sum[32] != sum[31]) ? (sum[32] ? PIX_MIN : PIX_MAX) : sum[31:0];
    upd_we  = 1'b0;
    pix_nxt = '0;
    if (hit_r) begin
      case (op_r)
        OP_ADD: begin
          upd_we  = 1'b1;
          pix_nxt = sum_sat;
        end
        OP_BLANK: begin
          upd_we  = keep_r;
          pix_nxt = keep_r ? factor_r : rd_r;
        end
        default: pix_nxt = rd_r;
      endcase
    end
  end

  assign mem_we    = cmd.clr_step || (cmd.ld_out && upd_we);
  assign mem_waddr = cmd.clr_step ? clr_r : addr_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd.clr_step ? 32'sd0 : pix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_pix_r    <= pix_nxt;
      out_inside_r <= hit_r;
    end
  end

  assign sts.clr_last = (clr_r == CLR_LAST);
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid   = out_valid_r;
  assign pixel_value = out_pix_r;
  assign inside_res  = out_inside_r;

  a_miss_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_out && !hit_r) |=> (pixel_value == 32'sd0) && !inside_res)
    else $error("clipped pixel returned a nonzero value");

  a_no_write_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_out && !hit_r) |-> !mem_we)
    else $error("frame store written for a pixel outside the frame");

  a_clear_counter_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_in || cmd.ld_out) |=> $stable(clr_r))
    else $error("clear counter moved during item processing");

endmodule

@@ src/clipped_stamp_compositor.sv @@
// Top level of the clipped stamp compositor: controller plus datapath.
// Depends on csc_pkg, csc_in_if, csc_out_if, csc_ctrl and csc_dp.
//
// Usage: each input beat carries one stamp pixel with an operation code:
// add (scaled sample into the pixel under the stamp centred on the anchor),
// blank (write factor where mask_keep is set, stamp corner at the anchor)
// or read (return the pixel at the anchor). Every beat gives exactly one
// result beat: the pixel value after the operation and an inside flag;
// pixels outside the frame or the stamp return zero with inside clear.
// Frame size comes from the cfg_ write port; write it only while idle.
// Sequence: an item passes through accept, address and multiply, store read
// and rounding, then update; the result is registered at the update, and a
// new item is taken only once the last one has finished its update. The single
// port frame store and its read-modify-write sequence keep one item in flight.
// Reset: a clearing pass writes zero to every store entry, one per cycle,
// MAX_WIDTH * MAX_HEIGHT entries (16384 by default); in_ch.ready stays low
// meanwhile, configuration writes are taken. A stalled receiver holds the
// result; the next item may be accepted but waits before its update.
module clipped_stamp_compositor
  import csc_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  csc_in_if.sink     in_ch,
  csc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  csc_cmd_t cmd;
  csc_sts_t sts;

  csc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .operation    (in_ch.operation),
    .stamp_width  (in_ch.stamp_width),
    .stamp_height (in_ch.stamp_height),
    .anchor_x     (in_ch.anchor_x),
    .anchor_y     (in_ch.anchor_y),
    .local_x      (in_ch.local_x),
    .local_y      (in_ch.local_y),
    .sample       (in_ch.sample),
    .factor       (in_ch.factor),
    .mask_keep    (in_ch.mask_keep),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .pixel_value  (out_ch.pixel_value),
    .inside_res   (out_ch.inside_res)
  );

endmodule

@@ dv/stamp_frame_checker.sv @@
// Checker for the clipped stamp compositor: watches both channels and the cfg port,
// keeps its own copy of the frame and size registers, and compares every result beat.
// Depends on csc_pkg, csc_in_if and csc_out_if.
module stamp_frame_checker
  import csc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  csc_in_if          in_mon,
  csc_out_if         out_mon,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         mismatches,
  output int         awaiting
);

  localparam int FRAME_W = 128;
  localparam int FRAME_H = 128;

  typedef struct packed {
    logic signed [31:0] pixel_value;
    logic               inside_res;
  } pixel_result_t;

  logic signed [31:0] frame_pixels [FRAME_W*FRAME_H];
  logic [7:0]         frame_width;
  logic [7:0]         frame_height;
  pixel_result_t      expected_pixels [$];
  int                 fail_count = 0;

  assign mismatches = fail_count;

  function automatic logic signed [31:0] sat_q16(longint v);
    if (v > PIX_MAX) return PIX_MAX;
    if (v < PIX_MIN) return PIX_MIN;
    return v[31:0];
  endfunction

  // Sizes above the store clamp to the store; a size of zero leaves no frame.
  function automatic bit in_frame(int x, int y);
    int w;
    int h;
    w = (frame_width > FRAME_W) ? FRAME_W : int'(frame_width);
    h = (frame_height > FRAME_H) ? FRAME_H : int'(frame_height);
    return x >= 0 && y >= 0 && x < w && y < h;
  endfunction

  // Apply one input beat to the frame copy and return the result it must give.
  function automatic pixel_result_t composite_pixel();
    pixel_result_t r;
    int            ax, ay, sw, sh, lx, ly, tx, ty, addr;
    longint        s, f, acc, term;
    r  = '0;
    ax = in_mon.anchor_x;
    ay = in_mon.anchor_y;
    sw = in_mon.stamp_width;
    sh = in_mon.stamp_height;
    lx = in_mon.local_x;
    ly = in_mon.local_y;
    s  = in_mon.sample;
    f  = in_mon.factor;
    if (in_mon.operation == OP_ADD || in_mon.operation == OP_BLANK) begin
      if (lx < sw && ly < sh) begin
        if (in_mon.operation == OP_ADD) begin
          // centred stamp: origin sits floor(size/2) before the anchor
          tx = ax - sw / 2 + lx;
          ty = ay - sh / 2 + ly;
        end else begin
          tx = ax + lx;
          ty = ay + ly;
        end
        if (in_frame(tx, ty)) begin
          addr = ty * FRAME_W + tx;
          r.inside_res = 1'b1;
          if (in_mon.operation == OP_ADD) begin
            // round Q32.32 to Q16.16: add half an LSB, floor
            term = sat_q16((s * f + 64'sd32768) >>> 16);
            acc  = frame_pixels[addr];
            frame_pixels[addr] = sat_q16(acc + term);
          end else if (in_mon.mask_keep) begin
            frame_pixels[addr] = in_mon.factor;
          end
          r.pixel_value = frame_pixels[addr];
        end
      end
    end else if (in_mon.operation == OP_READ) begin
      if (in_frame(ax, ay)) begin
        r.inside_res  = 1'b1;
        r.pixel_value = frame_pixels[ay * FRAME_W + ax];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      foreach (frame_pixels[i]) frame_pixels[i] = '0;
      frame_width  = IMAGE_SIZE_RESET;
      frame_height = IMAGE_SIZE_RESET;
      expected_pixels.delete();
    end else begin
      // results leave only after an accepted item's update, so check before queuing
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, got value %h inside %b",
                   $time, out_mon.pixel_value, out_mon.inside_res);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_mon.pixel_value !== want.pixel_value) begin
            $display("%0t: pixel_value expected %h got %h",
                     $time, want.pixel_value, out_mon.pixel_value);
            fail_count++;
          end
          if (out_mon.inside_res !== want.inside_res) begin
            $display("%0t: inside_res expected %b got %b",
                     $time, want.inside_res, out_mon.inside_res);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) expected_pixels.push_back(composite_pixel());
      if (cfg_we) begin
        if (cfg_index == CFG_IMAGE_WIDTH) frame_width = cfg_wdata;
        else frame_height = cfg_wdata;
      end
    end
    awaiting <= expected_pixels.size();
  end

endmodule

@@ dv/clipped_stamp_compositor_test.sv @@
// Testbench top for the clipped stamp compositor: clock, reset, frame size writes,
// directed and random stamp traffic with idle bursts on both channels, and the verdict.
// Depends on csc_pkg, csc_in_if, csc_out_if, clipped_stamp_compositor and stamp_frame_checker.
module clipped_stamp_compositor_test;
  import csc_pkg::*;

  localparam logic [1:0]         OP_SPARE     = 2'd3;
  localparam logic signed [31:0] Q_ONE        = 32'sh0001_0000;
  localparam int                 CYCLE_LIMIT  = 300000;
  localparam int                 STEADY_AFTER = 840;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;
  int         mismatches;
  int         awaiting;
  int         cycle_count = 0;
  int         sent_count  = 0;
  bit         steady      = 1'b0;

  csc_in_if  in_ch ();
  csc_out_if out_ch ();

  clipped_stamp_compositor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  stamp_frame_checker frame_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("clipped_stamp_compositor_test NOT OK");
      $finish;
    end
  end

  // Result side: random stall bursts, occasional long open stretches.
  initial begin
    int stall_left;
    int open_left;
    out_ch.ready = 1'b0;
    stall_left = 0;
    open_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (open_left > 0) open_left--;
        else if (!steady) begin
          case ($urandom_range(15))
            0, 1: stall_left = $urandom_range(15, 1);
            2:    open_left = $urandom_range(80, 20);
            default: ;
          endcase
        end
      end
    end
  end

  // Drive one stamp pixel beat and hold it until accepted; may idle first.
  task automatic send_px(input logic [1:0] op, input int sw, input int sh,
                         input int ax, input int ay, input int lx, input int ly,
                         input logic [31:0] sample, input logic [31:0] factor,
                         input logic keep);
    if (!steady && $urandom_range(4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.stamp_width  <= sw[7:0];
    in_ch.stamp_height <= sh[7:0];
    in_ch.anchor_x     <= ax[8:0];
    in_ch.anchor_y     <= ay[8:0];
    in_ch.local_x      <= lx[6:0];
    in_ch.local_y      <= ly[6:0];
    in_ch.sample       <= sample;
    in_ch.factor       <= factor;
    in_ch.mask_keep    <= keep;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  // Drop valid and hold until every result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic write_frame_size(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= w[7:0];
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= h[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_size();
    int p;
    p = $urandom_range(19);
    if (p < 16) return $urandom_range(6, 1);
    if (p < 19) return $urandom_range(128, 1);
    return $urandom_range(255);
  endfunction

  function automatic logic [31:0] pick_value(input bit full);
    // moderate values keep sums off the rails most of the time
    if (full) return $urandom;
    return $urandom_range(32'h0004_0000) - 32'h0002_0000;
  endfunction

  // One frame size, then stamps: raster sweeps or scattered pixels, some read back.
  task automatic random_phase(input int w, input int h, input int items);
    int         fw, fh, phase_sent, p, sw, sh, ax, ay, n, k, lx, ly, lx_top, ly_top;
    int         org_x, org_y;
    bit         full, sweep;
    logic [1:0] op;
    drain_results();
    write_frame_size(w, h);
    fw = (w > 128) ? 128 : w;
    fh = (h > 128) ? 128 : h;
    phase_sent = 0;
    while (phase_sent < items) begin
      p  = $urandom_range(99);
      op = (p < 45) ? OP_ADD : (p < 75) ? OP_BLANK : (p < 95) ? OP_READ : OP_SPARE;
      sw = pick_size();
      sh = pick_size();
      ax = ($urandom_range(9) == 0) ? int'($urandom_range(511)) - 256
                                    : int'($urandom_range(fw + 16)) - 8;
      ay = ($urandom_range(9) == 0) ? int'($urandom_range(511)) - 256
                                    : int'($urandom_range(fh + 16)) - 8;
      full   = ($urandom_range(4) == 0);
      sweep  = (sw * sh <= 36) && ($urandom_range(3) != 0);
      n      = sweep ? sw * sh : $urandom_range(6, 1);
      lx_top = (sw >= 127) ? 127 : sw;
      ly_top = (sh >= 127) ? 127 : sh;
      for (k = 0; k < n; k++) begin
        if (sweep) begin
          lx = k % sw;
          ly = k / sw;
        end else if ($urandom_range(9) == 0) begin
          lx = $urandom_range(127);
          ly = $urandom_range(127);
        end else begin
          // the top value sits just beyond the stamp unless it is wider than 127
          lx = $urandom_range(lx_top);
          ly = $urandom_range(ly_top);
        end
        send_px(op, sw, sh, ax, ay, lx, ly, pick_value(full), pick_value(full),
                $urandom_range(3) != 0);
        phase_sent++;
        steady = (sent_count >= STEADY_AFTER);
      end
      // read back part of the footprint just touched
      if ((op == OP_ADD || op == OP_BLANK) && sw > 0 && sh > 0 && $urandom_range(1)) begin
        org_x = (op == OP_ADD) ? ax - sw / 2 : ax;
        org_y = (op == OP_ADD) ? ay - sh / 2 : ay;
        for (k = 0; k < ((n > 8) ? 8 : n); k++) begin
          send_px(OP_READ, sw, sh, org_x + $urandom_range(lx_top - (lx_top == sw)),
                  org_y + $urandom_range(ly_top - (ly_top == sh)), 0, 0,
                  $urandom, $urandom, $urandom_range(1));
          phase_sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_IMAGE_WIDTH;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_ADD;
    in_ch.stamp_width  = '0;
    in_ch.stamp_height = '0;
    in_ch.anchor_x     = '0;
    in_ch.anchor_y     = '0;
    in_ch.local_x      = '0;
    in_ch.local_y      = '0;
    in_ch.sample       = '0;
    in_ch.factor       = '0;
    in_ch.mask_keep    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // the store clear runs now; size writes are taken meanwhile
    write_frame_size(128, 128);

    send_px(OP_READ, 1, 1, 0, 0, 0, 0, 0, 0, 1'b0);
    send_px(OP_ADD, 1, 1, 0, 0, 0, 0, Q_ONE, Q_ONE, 1'b0);
    send_px(OP_ADD, 1, 1, 0, 0, 0, 0, Q_ONE, -Q_ONE, 1'b0);
    // saturation of the rounded term and of the sum, both signs
    send_px(OP_ADD, 1, 1, 5, 5, 0, 0, PIX_MAX, PIX_MAX, 1'b1);
    send_px(OP_ADD, 1, 1, 5, 5, 0, 0, PIX_MAX, PIX_MAX, 1'b1);
    send_px(OP_ADD, 1, 1, 6, 6, 0, 0, PIX_MIN, PIX_MAX, 1'b0);
    send_px(OP_ADD, 1, 1, 6, 6, 0, 0, PIX_MIN, PIX_MAX, 1'b0);
    send_px(OP_ADD, 1, 1, 7, 7, 0, 0, PIX_MIN, PIX_MIN, 1'b0);
    // rounding: half up, negative half, just below negative half
    send_px(OP_ADD, 1, 1, 8, 8, 0, 0, 32'sd1, 32'sh8000, 1'b0);
    send_px(OP_ADD, 1, 1, 9, 9, 0, 0, -32'sd1, 32'sh8000, 1'b0);
    send_px(OP_ADD, 1, 1, 10, 10, 0, 0, -32'sd1, 32'sh8001, 1'b0);
    // odd stamp size centres on floor(size/2)
    send_px(OP_ADD, 5, 3, 20, 20, 4, 2, Q_ONE, 3 * Q_ONE, 1'b0);
    send_px(OP_READ, 5, 3, 22, 21, 0, 0, 0, 0, 1'b0);
    // blank at the far corner, then one pixel past the edge
    send_px(OP_BLANK, 4, 4, 127, 127, 0, 0, 0, PIX_MIN, 1'b1);
    send_px(OP_BLANK, 4, 4, 127, 127, 1, 0, 0, PIX_MIN, 1'b1);
    send_px(OP_BLANK, 1, 1, 5, 5, 0, 0, 0, Q_ONE, 1'b0);
    // local position beyond the stamp, then stamp size and anchor edge cases
    send_px(OP_ADD, 3, 3, 30, 30, 3, 0, Q_ONE, Q_ONE, 1'b1);
    send_px(OP_BLANK, 8, 8, 30, 30, 0, 8, Q_ONE, Q_ONE, 1'b1);
    send_px(OP_ADD, 128, 128, 0, 0, 127, 127, PIX_MAX, Q_ONE, 1'b1);
    send_px(OP_ADD, 255, 0, 40, 40, 0, 0, Q_ONE, Q_ONE, 1'b1);
    send_px(OP_ADD, 1, 1, -256, -256, 0, 0, Q_ONE, Q_ONE, 1'b1);
    send_px(OP_BLANK, 1, 1, 255, 255, 0, 0, Q_ONE, Q_ONE, 1'b1);
    send_px(OP_READ, 1, 1, -1, 0, 0, 0, 0, 0, 1'b0);
    send_px(OP_READ, 1, 1, 127, 127, 0, 0, 0, 0, 1'b0);
    send_px(OP_SPARE, 1, 1, 0, 0, 0, 0, Q_ONE, Q_ONE, 1'b1);

    random_phase(128, 128, 220);
    random_phase(1, 1, 60);
    random_phase(12, 9, 220);
    random_phase(0, 40, 40);
    random_phase(200, 255, 120);
    random_phase(73, 128, 250);

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("clipped_stamp_compositor_test OK");
    end else begin
      $display("clipped_stamp_compositor_test NOT OK");
    end
    $finish;
  end

endmodule
